>>> rtl/core/first_fit_coalescing_allocator_macros.svh
// assertion macros used by the checker file
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define FFCA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, checked out of reset
`define FFCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

>>> rtl/core/ffca_pkg.sv
`timescale 1ns / 1ps
package ffca_pkg;

    // alignment and header geometry
    localparam int unsigned ALIGN_BYTES = 8;
    localparam logic [32:0] ALIGN_MASK  = 33'h0_0000_0007;
    localparam int unsigned HDR_BYTES   = 16;
    localparam int unsigned MIN_SPLIT   = 2 * HDR_BYTES;

    // table depths
    localparam int unsigned FREE_ENTRIES_DEF = 64;
    localparam int unsigned USED_ENTRIES_DEF = 64;

    // register map
    localparam int unsigned REG_HEAP_BASE = 0;
    localparam int unsigned REG_HEAP_SIZE = 1;
    localparam logic [31:0] HEAP_BASE_RST = 32'h0001_0000;
    localparam logic [31:0] HEAP_SIZE_RST = 32'h0001_0000;

    // stream payload
    localparam int unsigned IN_W  = 64;
    localparam int unsigned OUT_W = 104;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // initial free block of the region
    typedef struct packed {
        logic        empty;
        logic [31:0] addr;
        logic [31:0] size;
    } init_blk_t;

endpackage

>>> rtl/core/ffca_ram.sv
`timescale 1ns / 1ps
module ffca_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/ffca_init.sv
`timescale 1ns / 1ps
module ffca_init (
    input  logic [31:0]         heap_base,
    input  logic [31:0]         heap_size,
    output ffca_pkg::init_blk_t blk
);
    import ffca_pkg::*;

    logic [32:0] start_a;
    logic [32:0] lim_raw;
    logic [32:0] lim;
    logic [32:0] end_a;
    logic [32:0] span;

    // start aligned up, end clamped to 4 GiB, less header, aligned down
    always_comb
    begin
        start_a = ({1'b0, heap_base} + 33'(ALIGN_BYTES - 1)) & ~ALIGN_MASK;
        lim_raw = {1'b0, heap_base} + {1'b0, heap_size};
        lim     = lim_raw[32] ? 33'h1_0000_0000 : lim_raw;
        end_a   = (lim - 33'(HDR_BYTES)) & ~ALIGN_MASK;
        span    = end_a - start_a;
        blk.empty = ((start_a + 33'(HDR_BYTES)) > lim) || (end_a <= start_a);
        blk.addr  = start_a[31:0];
        blk.size  = span[31:0];
    end

endmodule

>>> rtl/core/first_fit_coalescing_allocator.sv
`timescale 1ns / 1ps
// channel   | dir | handshake               | payload
// s (req)   | in  | s_tvalid / s_tready     | s_tuser: op; s_tdata: req_bytes, user_addr
// m (resp)  | out | m_tvalid / m_tready     | m_tdata: result_addr, status, free_bytes,
//           |     |                         |          min_free_bytes
// apb (cfg) | in  | psel, penable, pready=1 | heap_base at 0x0, heap_size at 0x4
//
// one request at a time; the free table walk reads one entry at a time (one read
// port, registered read), shifts on insert or remove move one entry at a time,
// and a free first walks the used table entry by entry, then the free table.
// after reset and after any register write the S_INIT state rebuilds the initial block;
// a finished word waits in the output register while the next request is taken.
module first_fit_coalescing_allocator #(
    parameter int unsigned FREE_ENTRIES = ffca_pkg::FREE_ENTRIES_DEF,
    parameter int unsigned USED_ENTRIES = ffca_pkg::USED_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ffca_pkg::IN_W-1:0]  s_tdata,   // req_bytes[31:0], user_addr[63:32]
    input  logic [0:0]                 s_tuser,   // op[0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ffca_pkg::OUT_W-1:0] m_tdata,   // result_addr[31:0], status[33:32],
                                                  // free_bytes[65:34], min_free_bytes[97:66]
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ffca_pkg::*;

    localparam int unsigned FI_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int unsigned UI_W = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
    localparam int unsigned CW   = $clog2(FREE_ENTRIES + 2);
    localparam int unsigned UCW  = $clog2(USED_ENTRIES + 2);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_RD, S_A_CHK, S_SH_RD, S_SH_WR, S_U_RD, S_U_CHK,
        S_F_RD, S_F_CHK, S_F_DEC, S_SI_RD, S_SI_WR, S_F_INS, S_DONE
    } state_t;

    state_t      state_reg;
    logic [31:0] base_reg;
    logic [31:0] size_reg;
    logic [32:0] want_reg;
    logic [31:0] ua_reg;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  p_reg;
    logic [UCW-1:0] uidx_reg;
    logic [UI_W-1:0] uhit_reg;
    logic [USED_ENTRIES-1:0] valid_reg;
    logic [31:0] s_reg;
    logic [31:0] z_reg;
    logic [31:0] prev_ad_reg;
    logic [31:0] prev_sz_reg;
    logic [31:0] cur_ad_reg;
    logic [31:0] cur_sz_reg;
    logic        cur_ok_reg;
    logic [31:0] bfree_reg;
    logic [31:0] blow_reg;
    status_t     status_reg;
    logic [31:0] res_reg;
    logic        mvalid_reg;
    logic [OUT_W-1:0] mdata_reg;

    init_blk_t   init_blk;

    // memory ports
    logic            fr_we;
    logic [FI_W-1:0] fr_waddr;
    logic [63:0]     fr_wdata;
    logic [63:0]     fr_rdata;
    logic            ur_we;
    logic [UI_W-1:0] ur_waddr;
    logic [63:0]     ur_wdata;
    logic [63:0]     ur_rdata;

    // decode helpers
    logic        cfg_wr;
    logic [31:0] in_req;
    logic [31:0] in_ua;
    logic [32:0] in_want;
    logic [31:0] fr_ad;
    logic [31:0] fr_sz;
    logic [31:0] ur_ad;
    logic [31:0] ur_sz;
    logic        a_fit;
    logic [32:0] a_rem;
    logic        a_split;
    logic [31:0] a_usz;
    logic [32:0] a_nad;
    logic        used_full;
    logic [UI_W-1:0] first_free;
    logic [CW:0]  idx_inc;
    logic [CW-1:0] idx_dec;
    logic [UCW:0] uidx_inc;
    logic [32:0] u_sum;
    logic        u_match;
    logic [32:0] prev_end;
    logic [32:0] s_end;
    logic        mp;
    logic        mn;
    logic [31:0] mrg_both;
    logic [31:0] mrg_prev;
    logic [31:0] mrg_next;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'(REG_HEAP_SIZE)) ? size_reg : base_reg;
    assign s_tready = (state_reg == S_IDLE) && !cfg_wr;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    ffca_init u_init (
        .heap_base (base_reg),
        .heap_size (size_reg),
        .blk       (init_blk)
    );

    ffca_ram #(.WIDTH(64), .DEPTH(FREE_ENTRIES), .AW(FI_W)) u_free_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (idx_reg[FI_W-1:0]),
        .rdata (fr_rdata)
    );

    ffca_ram #(.WIDTH(64), .DEPTH(USED_ENTRIES), .AW(UI_W)) u_used_ram (
        .clk   (clk),
        .we    (ur_we),
        .waddr (ur_waddr),
        .wdata (ur_wdata),
        .raddr (uidx_reg[UI_W-1:0]),
        .rdata (ur_rdata)
    );

    // lowest free slot of the used table
    always_comb
    begin
        first_free = '0;
        for (int i = USED_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                first_free = UI_W'(i);
            end
        end
    end

    // per-state arithmetic
    always_comb
    begin
        in_req   = s_tdata[31:0];
        in_ua    = s_tdata[63:32];
        in_want  = ({1'b0, in_req} + 33'(HDR_BYTES + ALIGN_BYTES - 1)) & ~ALIGN_MASK;
        fr_ad    = fr_rdata[31:0];
        fr_sz    = fr_rdata[63:32];
        ur_ad    = ur_rdata[31:0];
        ur_sz    = ur_rdata[63:32];
        a_fit    = {1'b0, fr_sz} >= want_reg;
        a_rem    = {1'b0, fr_sz} - want_reg;
        a_split  = a_rem > 33'(MIN_SPLIT);
        a_usz    = a_split ? want_reg[31:0] : fr_sz;
        a_nad    = {1'b0, fr_ad} + want_reg;
        used_full = &valid_reg;
        idx_inc  = {1'b0, idx_reg} + 1'b1;
        idx_dec  = idx_reg - 1'b1;
        uidx_inc = {1'b0, uidx_reg} + 1'b1;
        u_sum    = {1'b0, ur_ad} + 33'(HDR_BYTES);
        u_match  = valid_reg[uidx_reg[UI_W-1:0]] && (u_sum == {1'b0, ua_reg});
        prev_end = {1'b0, prev_ad_reg} + {1'b0, prev_sz_reg};
        s_end    = {1'b0, s_reg} + {1'b0, z_reg};
        mp       = (idx_reg != '0) && (prev_end == {1'b0, s_reg});
        mn       = cur_ok_reg && (s_end == {1'b0, cur_ad_reg});
        mrg_both = prev_sz_reg + z_reg + cur_sz_reg;
        mrg_prev = prev_sz_reg + z_reg;
        mrg_next = cur_sz_reg + z_reg;
    end

    // free table write port
    always_comb
    begin
        fr_we    = 1'b0;
        fr_waddr = idx_reg[FI_W-1:0];
        fr_wdata = fr_rdata;
        unique case (state_reg)
            S_INIT:
            begin
                fr_we    = !init_blk.empty;
                fr_waddr = '0;
                fr_wdata = {init_blk.size, init_blk.addr};
            end
            S_A_CHK:
            begin
                fr_we    = a_fit && !used_full && a_split;
                fr_wdata = {a_rem[31:0], a_nad[31:0]};
            end
            S_SH_WR:
            begin
                fr_we    = 1'b1;
                fr_waddr = idx_dec[FI_W-1:0];
            end
            S_F_DEC:
            begin
                if (mp && mn)
                begin
                    fr_we    = 1'b1;
                    fr_waddr = idx_dec[FI_W-1:0];
                    fr_wdata = {mrg_both, prev_ad_reg};
                end
                else if (mp)
                begin
                    fr_we    = 1'b1;
                    fr_waddr = idx_dec[FI_W-1:0];
                    fr_wdata = {mrg_prev, prev_ad_reg};
                end
                else if (mn)
                begin
                    fr_we    = 1'b1;
                    fr_wdata = {mrg_next, s_reg};
                end
                else
                begin
                    fr_we    = (cnt_reg != CW'(FREE_ENTRIES)) && (idx_reg == cnt_reg);
                    fr_wdata = {z_reg, s_reg};
                end
            end
            S_SI_WR:
            begin
                fr_we    = 1'b1;
                fr_waddr = idx_inc[FI_W-1:0];
            end
            S_F_INS:
            begin
                fr_we    = 1'b1;
                fr_waddr = p_reg[FI_W-1:0];
                fr_wdata = {z_reg, s_reg};
            end
            default:
            begin
                fr_we = 1'b0;
            end
        endcase
    end

    // used table write port
    always_comb
    begin
        ur_we    = (state_reg == S_A_CHK) && a_fit && !used_full;
        ur_waddr = first_free;
        ur_wdata = {a_usz, fr_ad};
    end

    // control sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            base_reg   <= HEAP_BASE_RST;
            size_reg   <= HEAP_SIZE_RST;
            cnt_reg    <= '0;
            valid_reg  <= '0;
            bfree_reg  <= '0;
            blow_reg   <= '0;
            mvalid_reg <= 1'b0;
            idx_reg    <= '0;
            uidx_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            // a register write rebuilds the heap
            if (mvalid_reg && m_tready)
            begin
                mvalid_reg <= 1'b0;
            end
            if (paddr[2] == 1'(REG_HEAP_SIZE))
            begin
                size_reg <= pwdata;
            end
            else
            begin
                base_reg <= pwdata;
            end
            state_reg <= S_INIT;
        end
        else
        begin
            if (mvalid_reg && m_tready && state_reg != S_DONE)
            begin
                mvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_INIT:
                begin
                    cnt_reg   <= init_blk.empty ? CW'(0) : CW'(1);
                    bfree_reg <= init_blk.empty ? 32'd0 : init_blk.size;
                    blow_reg  <= init_blk.empty ? 32'd0 : init_blk.size;
                    valid_reg <= '0;
                    state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        want_reg <= in_want;
                        ua_reg   <= in_ua;
                        res_reg  <= '0;
                        idx_reg  <= '0;
                        uidx_reg <= '0;
                        if (s_tuser[0] == OP_ALLOC)
                        begin
                            if (in_req == '0 || in_want > {1'b0, bfree_reg} || cnt_reg == '0)
                            begin
                                status_reg <= ST_NO_FIT;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_A_RD;
                            end
                        end
                        else if (in_ua == '0)
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_U_RD;
                        end
                    end
                end
                S_A_RD:
                begin
                    state_reg <= S_A_CHK;
                end
                S_A_CHK:
                begin
                    if (a_fit)
                    begin
                        if (used_full)
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            valid_reg[first_free] <= 1'b1;
                            bfree_reg  <= bfree_reg - a_usz;
                            if (bfree_reg - a_usz < blow_reg)
                            begin
                                blow_reg <= bfree_reg - a_usz;
                            end
                            res_reg    <= fr_ad + 32'(HDR_BYTES);
                            status_reg <= ST_OK;
                            if (a_split)
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                idx_reg <= idx_inc[CW-1:0];
                                if (idx_inc < {1'b0, cnt_reg})
                                begin
                                    state_reg <= S_SH_RD;
                                end
                                else
                                begin
                                    cnt_reg   <= cnt_reg - 1'b1;
                                    state_reg <= S_DONE;
                                end
                            end
                        end
                    end
                    else if (idx_inc < {1'b0, cnt_reg})
                    begin
                        idx_reg   <= idx_inc[CW-1:0];
                        state_reg <= S_A_RD;
                    end
                    else
                    begin
                        status_reg <= ST_NO_FIT;
                        state_reg  <= S_DONE;
                    end
                end
                // close the gap left by a removed entry
                S_SH_RD:
                begin
                    state_reg <= S_SH_WR;
                end
                S_SH_WR:
                begin
                    if (idx_inc < {1'b0, cnt_reg})
                    begin
                        idx_reg   <= idx_inc[CW-1:0];
                        state_reg <= S_SH_RD;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                // look up the block being freed
                S_U_RD:
                begin
                    state_reg <= S_U_CHK;
                end
                S_U_CHK:
                begin
                    if (u_match)
                    begin
                        s_reg      <= ur_ad;
                        z_reg      <= ur_sz;
                        uhit_reg   <= uidx_reg[UI_W-1:0];
                        idx_reg    <= '0;
                        cur_ok_reg <= 1'b0;
                        state_reg  <= (cnt_reg == '0) ? S_F_DEC : S_F_RD;
                    end
                    else if (uidx_inc < (UCW + 1)'(USED_ENTRIES))
                    begin
                        uidx_reg  <= uidx_inc[UCW-1:0];
                        state_reg <= S_U_RD;
                    end
                    else
                    begin
                        status_reg <= ST_NOT_ALLOC;
                        state_reg  <= S_DONE;
                    end
                end
                // find the first free entry above the block
                S_F_RD:
                begin
                    state_reg <= S_F_CHK;
                end
                S_F_CHK:
                begin
                    if (fr_ad > s_reg)
                    begin
                        cur_ad_reg <= fr_ad;
                        cur_sz_reg <= fr_sz;
                        cur_ok_reg <= 1'b1;
                        state_reg  <= S_F_DEC;
                    end
                    else
                    begin
                        prev_ad_reg <= fr_ad;
                        prev_sz_reg <= fr_sz;
                        idx_reg     <= idx_inc[CW-1:0];
                        state_reg   <= (idx_inc < {1'b0, cnt_reg}) ? S_F_RD : S_F_DEC;
                    end
                end
                // merge or insert
                S_F_DEC:
                begin
                    p_reg <= idx_reg;
                    if (!mp && !mn && cnt_reg == CW'(FREE_ENTRIES))
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        valid_reg[uhit_reg] <= 1'b0;
                        bfree_reg  <= bfree_reg + z_reg;
                        status_reg <= ST_OK;
                        if (mp && mn)
                        begin
                            idx_reg <= idx_inc[CW-1:0];
                            if (idx_inc < {1'b0, cnt_reg})
                            begin
                                state_reg <= S_SH_RD;
                            end
                            else
                            begin
                                cnt_reg   <= cnt_reg - 1'b1;
                                state_reg <= S_DONE;
                            end
                        end
                        else if (mp || mn)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (idx_reg == cnt_reg)
                        begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= cnt_reg - 1'b1;
                            state_reg <= S_SI_RD;
                        end
                    end
                end
                // open a slot, moving entries up from the top
                S_SI_RD:
                begin
                    state_reg <= S_SI_WR;
                end
                S_SI_WR:
                begin
                    if (idx_reg == p_reg)
                    begin
                        state_reg <= S_F_INS;
                    end
                    else
                    begin
                        idx_reg   <= idx_dec;
                        state_reg <= S_SI_RD;
                    end
                end
                S_F_INS:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!mvalid_reg || m_tready)
                    begin
                        mvalid_reg <= 1'b1;
                        mdata_reg  <= {6'd0, blow_reg, bfree_reg, status_reg, res_reg};
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_INIT;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/ffca_checker.sv
`timescale 1ns / 1ps
`include "first_fit_coalescing_allocator_macros.svh"
module ffca_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [ffca_pkg::OUT_W-1:0] m_tdata
);
    import ffca_pkg::*;

    logic [31:0] res_addr;
    logic [1:0]  res_status;
    logic [31:0] res_free;
    logic [31:0] res_low;

    assign res_addr   = m_tdata[31:0];
    assign res_status = m_tdata[33:32];
    assign res_free   = m_tdata[65:34];
    assign res_low    = m_tdata[97:66];

    // a stalled word stays offered
    `FFCA_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    // low-water mark never above the current free count
    `FFCA_ASSERT_NOW(a_low_le_free, m_tvalid, res_low <= res_free)
    // failures never carry an address
    `FFCA_ASSERT_NOW(a_fail_no_addr, m_tvalid && res_status != ST_OK, res_addr == '0)
    // returned addresses keep the block alignment
    `FFCA_ASSERT_NOW(a_addr_aligned, m_tvalid, res_addr[2:0] == 3'd0)

endmodule

bind first_fit_coalescing_allocator ffca_checker u_ffca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
